>>> rtl/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg: shared types and constants for the threshold dense-to-CSR unit
// Holds the result record, the queue entry and the register indexes.
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam logic [0:0] CFG_THRESHOLD = 1'd0;
  localparam logic [0:0] CFG_ROW_LEN   = 1'd1;

  localparam logic KIND_COLUMN = 1'b0;
  localparam logic KIND_OFFSET = 1'b1;

  localparam logic [32:0] TOTAL_MAX = 33'h1_0000_0000;
  localparam logic [16:0] KEPT_MAX  = 17'h1_ffff;

  // results of the head element already sent
  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_START_DONE,
    STEP_COLUMN_DONE
  } tdc_step_t;

  // one classified element with up to three results
  typedef struct packed {
    logic        start;
    logic        keep;
    logic        row_end;
    logic [15:0] column;
    logic [15:0] row;
    logic [16:0] kept;
    logic [32:0] total;
  } tdc_entry_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] column_index;
    logic [15:0] row_num;
    logic [16:0] row_kept;
    logic [32:0] row_offset;
    logic        last;
  } tdc_result_t;

endpackage

>>> rtl/tdc_front.sv
// ----------------------------------------------------------------------------
// tdc_front: classify elements and update the row counters
// Compares the magnitude with the threshold and tracks column, row, counts.
// ----------------------------------------------------------------------------
module tdc_front
  import tdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        take,
  input  logic [31:0] element_bits,
  input  logic        matrix_start,
  output tdc_entry_t  entry
);

  logic [31:0] thr_r;
  logic [16:0] len_r;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [16:0] kept_r, kept_nxt;
  logic [32:0] total_r, total_nxt;
  logic [30:0] mag, tmag;
  logic        keep;
  logic [16:0] len_eff;
  logic [15:0] col0, row0;
  logic [16:0] kept0, kept1;
  logic [32:0] total0, total1;
  logic        row_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      len_r <= 17'h1_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r <= cfg_wdata;
        CFG_ROW_LEN:   len_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mag  = element_bits[30:0];
    tmag = thr_r[30:0];
    if (mag > 31'h7f80_0000 || tmag > 31'h7f80_0000) keep = 1'b0;
    else if (thr_r[31]) keep = 1'b1;
    else keep = (mag >= tmag);
    len_eff = (len_r == 17'd0 || len_r > 17'h1_0000) ? 17'h1_0000 : len_r;
    col0   = matrix_start ? '0 : col_r;
    row0   = matrix_start ? '0 : row_r;
    kept0  = matrix_start ? '0 : kept_r;
    total0 = matrix_start ? '0 : total_r;
    kept1  = (keep && kept0 < KEPT_MAX) ? kept0 + 17'd1 : kept0;
    total1 = (keep && total0 < TOTAL_MAX) ? total0 + 33'd1 : total0;
    row_end = ({1'b0, col0} + 17'd1) >= len_eff;
    total_nxt = total1;
    if (row_end) begin
      col_nxt  = '0;
      row_nxt  = row0 + 16'd1;
      kept_nxt = '0;
    end else begin
      col_nxt  = col0 + 16'd1;
      row_nxt  = row0;
      kept_nxt = kept1;
    end
    entry.start   = matrix_start;
    entry.keep    = keep;
    entry.row_end = row_end;
    entry.column  = col0;
    entry.row     = row0;
    entry.kept    = kept1;
    entry.total   = total1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      kept_r  <= '0;
      total_r <= '0;
    end else if (take) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      kept_r  <= kept_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

>>> rtl/tdc_queue.sv
// ----------------------------------------------------------------------------
// tdc_queue: short queue of classified elements
// Four-entry register queue parting the front and back stages.
// ----------------------------------------------------------------------------
module tdc_queue
  import tdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tdc_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output tdc_entry_t head
);

  tdc_entry_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full      = (cnt_r == 3'd4);
  assign not_empty = (cnt_r != 3'd0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule

>>> rtl/tdc_back.sv
// ----------------------------------------------------------------------------
// tdc_back: expand one classified element into its results
// Walks start, column and row-end results into a registered output.
// ----------------------------------------------------------------------------
module tdc_back
  import tdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  tdc_entry_t  q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output tdc_result_t out_res
);

  tdc_step_t   step_r, step_nxt;
  logic        ov_r;
  tdc_result_t res_r;
  logic        load;
  logic        no_res;
  tdc_result_t res;
  logic        more_k;

  // elements with no result leave the queue without touching the output
  assign no_res    = !(q_head.start || q_head.keep || q_head.row_end);
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign load      = q_valid && !no_res && (!ov_r || out_ready);

  always_comb begin
    res      = '0;
    step_nxt = step_r;
    more_k   = q_head.keep || q_head.row_end;
    q_pop    = q_valid && no_res;
    priority if (q_head.start && step_r == STEP_IDLE) begin
      res.kind = KIND_OFFSET;
      res.last = !more_k;
      step_nxt = STEP_START_DONE;
    end else if (q_head.keep && step_r != STEP_COLUMN_DONE) begin
      res.kind         = KIND_COLUMN;
      res.column_index = q_head.column;
      res.row_num      = q_head.row;
      res.row_offset   = q_head.total;
      res.last         = !q_head.row_end;
      step_nxt         = STEP_COLUMN_DONE;
    end else begin
      res.kind       = KIND_OFFSET;
      res.row_num    = q_head.row;
      res.row_kept   = q_head.kept;
      res.row_offset = q_head.total;
      res.last       = 1'b1;
    end
    if (load && res.last) begin
      q_pop    = 1'b1;
      step_nxt = STEP_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      step_r <= STEP_IDLE;
    end else begin
      if (load) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (load) step_r <= step_nxt;
    end
  end

endmodule

>>> rtl/threshold_dense_to_csr_unit.sv
// ----------------------------------------------------------------------------
// threshold_dense_to_csr_unit: threshold sparsifier from dense rows to CSR
// One float32 element is taken per cycle while the queue is not full; each
// yields up to three results (matrix-start offset, kept column, row-end
// offset) delivered one per cycle while out_tready is high, so sustained rate
// is one element per cycle when each yields at most one result. A four-entry
// queue parts the classifying front from the registered output sequencer.
// ----------------------------------------------------------------------------
module threshold_dense_to_csr_unit
  import tdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // element_bits
  input  logic        in_tuser,   // matrix_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // column_index, row_num, row_kept, row_offset
  output logic        out_tuser,  // kind
  output logic        out_tlast   // last
);

  tdc_entry_t  entry, head;
  tdc_result_t res;
  logic        full, take, q_valid, q_pop;

  assign in_tready = !full;
  assign take      = in_tvalid && in_tready;

  tdc_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .take,
    .element_bits(in_tdata), .matrix_start(in_tuser), .entry
  );

  tdc_queue u_queue (
    .clk, .rst_n, .push(take), .push_data(entry), .full,
    .pop(q_pop), .not_empty(q_valid), .head
  );

  tdc_back u_back (
    .clk, .rst_n, .q_valid, .q_head(head), .q_pop,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {6'd0, res.row_offset, res.row_kept, res.row_num, res.column_index};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

`ifndef SYNTHESIS
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop without queued element");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !take)
    else $error("request taken while queue full");
`endif

endmodule
